FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every edge outside reset
`define VRU_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// expression must never be true outside reset
`define VRU_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) else $error(msg);
`else
`define VRU_ASSERT(lbl, clk, rstn, prop, msg)
`define VRU_NEVER(lbl, clk, rstn, expr, msg)
`endif

`endif

FILE: rtl/core/vru_pkg.sv
// ----------------------------------------------------------------------------
// vru_pkg
// Widths, payload and pipeline types of the vector reflect unit.
// ----------------------------------------------------------------------------
package vru_pkg;

    localparam int COMP_WIDTH = 32;
    localparam int PROD_W     = 2 * COMP_WIDTH;      // one component product
    localparam int SUM_W      = PROD_W + 2;          // signed dot product
    localparam int MAG_W      = PROD_W;              // |d.n| and n.n
    localparam int DEN_W      = PROD_W + 1;          // 2*(n.n)
    localparam int QUO_W      = COMP_WIDTH + 2;      // |correction| bound
    localparam int NUM_W      = 3 * COMP_WIDTH + 3;  // 4*|n_i|*|s| + q
    localparam int RES_W      = COMP_WIDTH + 3;      // d - corr before clamp
    localparam int LANES      = 3;

    typedef logic signed [COMP_WIDTH-1:0] comp_t;
    typedef logic        [COMP_WIDTH-1:0] umag_t;

    typedef struct packed {
        comp_t incident_x;
        comp_t incident_y;
        comp_t incident_z;
        comp_t normal_x;
        comp_t normal_y;
        comp_t normal_z;
    } vru_in_t;

    typedef struct packed {
        comp_t reflected_x;
        comp_t reflected_y;
        comp_t reflected_z;
        logic  zero_normal;
    } vru_out_t;

    // carried alongside the arithmetic to the last stage
    typedef struct packed {
        logic [LANES-1:0][COMP_WIDTH-1:0] inc;
        logic [LANES-1:0]                 n_neg;
        logic                             s_neg;
        logic                             zero;
    } vru_tag_t;

    typedef struct packed {
        vru_tag_t                         tag;
        logic [LANES-1:0][COMP_WIDTH-1:0] n_mag;
        logic [MAG_W-1:0]                 s_mag;
        logic [MAG_W-1:0]                 q;
    } vru_dot_t;

    typedef struct packed {
        vru_tag_t                         tag;
        logic [DEN_W-1:0]                 den;
        logic [LANES-1:0][NUM_W-1:0]      rem;
        logic [LANES-1:0][QUO_W-1:0]      quo;
    } vru_div_t;

endpackage

FILE: rtl/core/vru_dot.sv
// ----------------------------------------------------------------------------
// vru_dot
// Two stages: component products, then d.n and n.n sums.
// ----------------------------------------------------------------------------
module vru_dot
    import vru_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  vru_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output vru_dot_t out_data
);

    logic signed [PROD_W-1:0]         p_reg  [LANES];
    logic signed [PROD_W-1:0]         sq_reg [LANES];
    logic [LANES-1:0][COMP_WIDTH-1:0] nmag_reg;
    logic [LANES-1:0][COMP_WIDTH-1:0] inc_reg;
    logic [LANES-1:0]                 nneg_reg;
    logic                             v1_reg;
    logic                             v2_reg;
    vru_dot_t                         dot_reg;
    vru_dot_t                         dot_next;
    logic                             en1;
    logic                             en2;
    comp_t                            d_vec [LANES];
    comp_t                            n_vec [LANES];

    assign en2      = !v2_reg || out_ready;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    assign d_vec[0] = in_data.incident_x;
    assign d_vec[1] = in_data.incident_y;
    assign d_vec[2] = in_data.incident_z;
    assign n_vec[0] = in_data.normal_x;
    assign n_vec[1] = in_data.normal_y;
    assign n_vec[2] = in_data.normal_z;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (en1) begin
                v1_reg <= in_valid;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            for (int i = 0; i < LANES; i++) begin
                p_reg[i]    <= PROD_W'(d_vec[i]) * PROD_W'(n_vec[i]);
                sq_reg[i]   <= PROD_W'(n_vec[i]) * PROD_W'(n_vec[i]);
                nmag_reg[i] <= n_vec[i][COMP_WIDTH-1] ? COMP_WIDTH'(-n_vec[i])
                                                      : COMP_WIDTH'(n_vec[i]);
                inc_reg[i]  <= d_vec[i];
                nneg_reg[i] <= n_vec[i][COMP_WIDTH-1];
            end
        end
        if (en2) begin
            dot_reg <= dot_next;
        end
    end

    always_comb begin
        logic signed [SUM_W-1:0] s_sum;
        logic [MAG_W-1:0]        q_sum;
        s_sum = SUM_W'(p_reg[0]) + SUM_W'(p_reg[1]) + SUM_W'(p_reg[2]);
        q_sum = MAG_W'(sq_reg[0]) + MAG_W'(sq_reg[1]) + MAG_W'(sq_reg[2]);
        dot_next           = '0;
        dot_next.tag.inc   = inc_reg;
        dot_next.tag.n_neg = nneg_reg;
        dot_next.tag.s_neg = s_sum[SUM_W-1];
        dot_next.tag.zero  = (q_sum == '0);
        dot_next.n_mag     = nmag_reg;
        dot_next.s_mag     = s_sum[SUM_W-1] ? MAG_W'(-s_sum) : MAG_W'(s_sum);
        dot_next.q         = q_sum;
    end

    assign out_valid = v2_reg;
    assign out_data  = dot_reg;

endmodule

FILE: rtl/core/vru_scale.sv
// ----------------------------------------------------------------------------
// vru_scale
// Two stages: |n_i|*|s| as half products, then dividend and divisor.
// ----------------------------------------------------------------------------
module vru_scale
    import vru_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  vru_dot_t in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output vru_div_t out_data
);

    logic [PROD_W-1:0] lo_reg [LANES];
    logic [PROD_W-1:0] hi_reg [LANES];
    logic [MAG_W-1:0]  q_reg;
    vru_tag_t          tag_reg;
    vru_div_t          div_reg;
    vru_div_t          div_next;
    logic              v1_reg;
    logic              v2_reg;
    logic              en1;
    logic              en2;

    assign en2      = !v2_reg || out_ready;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (en1) begin
                v1_reg <= in_valid;
            end
            if (en2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            for (int i = 0; i < LANES; i++) begin
                lo_reg[i] <= PROD_W'(in_data.n_mag[i]) *
                             PROD_W'(in_data.s_mag[COMP_WIDTH-1:0]);
                hi_reg[i] <= PROD_W'(in_data.n_mag[i]) *
                             PROD_W'(in_data.s_mag[MAG_W-1:COMP_WIDTH]);
            end
            q_reg   <= in_data.q;
            tag_reg <= in_data.tag;
        end
        if (en2) begin
            div_reg <= div_next;
        end
    end

    // dividend 4*|n_i|*|s| + q rounds the quotient half away from zero
    always_comb begin
        div_next     = '0;
        div_next.tag = tag_reg;
        div_next.den = {q_reg, 1'b0};
        for (int i = 0; i < LANES; i++) begin
            div_next.rem[i] = ((NUM_W'(hi_reg[i]) << COMP_WIDTH) + NUM_W'(lo_reg[i])) << 2;
            div_next.rem[i] = div_next.rem[i] + NUM_W'(q_reg);
        end
    end

    assign out_valid = v2_reg;
    assign out_data  = div_reg;

endmodule

FILE: rtl/core/vru_div.sv
// ----------------------------------------------------------------------------
// vru_div
// Pipelined restoring divider, one quotient bit per stage, three lanes.
// ----------------------------------------------------------------------------
module vru_div
    import vru_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  vru_div_t in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output vru_div_t out_data
);

    vru_div_t stage_q   [QUO_W+1];
    logic     stage_v   [QUO_W+1];
    logic     stage_rdy [QUO_W+1];

    assign stage_q[0]       = in_data;
    assign stage_v[0]       = in_valid;
    assign stage_rdy[QUO_W] = out_ready;
    assign in_ready         = stage_rdy[0];

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        localparam int BIT = QUO_W - 1 - k;
        vru_div_t st_reg;
        vru_div_t st_next;
        logic     v_reg;

        assign stage_rdy[k] = !v_reg || stage_rdy[k+1];

        always_comb begin
            logic [NUM_W-1:0] trial;
            st_next = stage_q[k];
            trial   = NUM_W'(stage_q[k].den) << BIT;
            for (int i = 0; i < LANES; i++) begin
                if (stage_q[k].rem[i] >= trial) begin
                    st_next.rem[i]      = stage_q[k].rem[i] - trial;
                    st_next.quo[i][BIT] = 1'b1;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg <= 1'b0;
            end else if (stage_rdy[k]) begin
                v_reg <= stage_v[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (stage_rdy[k]) begin
                st_reg <= st_next;
            end
        end

        assign stage_q[k+1] = st_reg;
        assign stage_v[k+1] = v_reg;
    end

    assign out_valid = stage_v[QUO_W];
    assign out_data  = stage_q[QUO_W];

endmodule

FILE: rtl/core/vector_reflect_unit.sv
// ----------------------------------------------------------------------------
// vector_reflect_unit
// Reflection of a Q16.16 3-vector about an arbitrary-length normal.
// ----------------------------------------------------------------------------
// Computes r = d - 2*n*(d.n)/(n.n) exactly on the raw integers, the
// correction rounded to nearest (ties away from zero) and each component
// saturated to the 32-bit signed range. A zero normal passes d through and
// sets zero_normal. The unit takes one transaction per clock unless m_ready
// stalls it; a transaction goes from s_valid/s_ready to m_valid through two stages for the
// component products and the dot sums, two for |n_i|*|d.n| and the dividend,
// 34 stages of the restoring divider (one quotient bit each) and the output
// register with the subtract and clamp. Every stage holds its own valid bit
// and loads whenever it is empty or the stage after it moves, so bubbles
// close up and a stalled m_ready backs up one stage at a time.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vector_reflect_unit
    import vru_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  vru_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output vru_out_t m_data
);

    // stage links
    logic     dot_valid;
    logic     dot_ready;
    vru_dot_t dot_data;
    logic     scl_valid;
    logic     scl_ready;
    vru_div_t scl_data;
    logic     div_valid;
    logic     div_ready;
    vru_div_t div_data;

    // output register
    logic     m_valid_reg;
    vru_out_t m_data_reg;
    vru_out_t m_data_next;

    vru_dot u_dot (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (dot_valid),
        .out_ready (dot_ready),
        .out_data  (dot_data)
    );

    vru_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (dot_valid),
        .in_ready  (dot_ready),
        .in_data   (dot_data),
        .out_valid (scl_valid),
        .out_ready (scl_ready),
        .out_data  (scl_data)
    );

    vru_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (scl_valid),
        .in_ready  (scl_ready),
        .in_data   (scl_data),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .out_data  (div_data)
    );

    assign div_ready = !m_valid_reg || m_ready;

    // sign the correction, subtract from d, clamp
    always_comb begin
        logic signed [RES_W-1:0] mag;
        logic signed [RES_W-1:0] corr;
        logic signed [RES_W-1:0] diff;
        comp_t                   res [LANES];
        for (int i = 0; i < LANES; i++) begin
            mag  = RES_W'(div_data.quo[i]);
            corr = (div_data.tag.s_neg ^ div_data.tag.n_neg[i]) ? -mag : mag;
            diff = RES_W'($signed(div_data.tag.inc[i])) - corr;
            if (div_data.tag.zero) begin
                res[i] = $signed(div_data.tag.inc[i]);
            end else if (diff > RES_W'($signed({1'b0, {(COMP_WIDTH-1){1'b1}}}))) begin
                res[i] = {1'b0, {(COMP_WIDTH-1){1'b1}}};
            end else if (diff < RES_W'($signed({1'b1, {(COMP_WIDTH-1){1'b0}}}))) begin
                res[i] = {1'b1, {(COMP_WIDTH-1){1'b0}}};
            end else begin
                res[i] = diff[COMP_WIDTH-1:0];
            end
        end
        m_data_next.reflected_x = res[0];
        m_data_next.reflected_y = res[1];
        m_data_next.reflected_z = res[2];
        m_data_next.zero_normal = div_data.tag.zero;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (div_ready) begin
            m_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (div_ready) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // zero flag taken from n.n must agree with the divisor built two stages later
    `VRU_ASSERT(a_zero_den, aclk, aresetn,
        div_valid |-> (div_data.tag.zero == (div_data.den == '0)),
        "zero flag and divisor disagree")
    // quotient fits: every nonzero-normal lane ends with remainder below divisor
    `VRU_ASSERT(a_rem_x, aclk, aresetn,
        (div_valid && !div_data.tag.zero) |-> (div_data.rem[0] < NUM_W'(div_data.den)),
        "divider overflow, lane x")
    `VRU_ASSERT(a_rem_y, aclk, aresetn,
        (div_valid && !div_data.tag.zero) |-> (div_data.rem[1] < NUM_W'(div_data.den)),
        "divider overflow, lane y")
    `VRU_ASSERT(a_rem_z, aclk, aresetn,
        (div_valid && !div_data.tag.zero) |-> (div_data.rem[2] < NUM_W'(div_data.den)),
        "divider overflow, lane z")
    // input may only stall when the output is blocked
    `VRU_NEVER(a_no_idle_stall, aclk, aresetn,
        !s_ready && !(m_valid && !m_ready),
        "input stalled with output free")

endmodule
